// ===== rtl/core/bpsm_pkg.sv =====
// Shared types and constants for the buffer pool slot manager.
// No dependencies; used by bpsm_scan and buffer_pool_slot_manager_core.
package bpsm_pkg;

	localparam int SLOTS    = 16;
	localparam int SLOT_W   = 4;
	localparam int AGE_BITS = 16;
	localparam int FILE_W   = 8;
	localparam int BLOCK_W  = 24;
	localparam int TABLE_W  = 15;
	localparam int OP_W     = 3;

	localparam logic [AGE_BITS-1:0] AGE_MAX  = '1;
	localparam logic [SLOT_W-1:0]   LAST_IDX = SLOT_W'(SLOTS - 1);

	localparam logic [OP_W-1:0] OP_READ  = 3'd0;
	localparam logic [OP_W-1:0] OP_NEW   = 3'd1;
	localparam logic [OP_W-1:0] OP_UNPIN = 3'd2;
	localparam logic [OP_W-1:0] OP_DIRTY = 3'd3;
	localparam logic [OP_W-1:0] OP_FLUSH = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_COMMIT = 4'b0100,
		ST_FLUSH  = 4'b1000
	} state_t;

	// One frame as seen by the scan unit.
	typedef struct packed {
		logic                valid;
		logic                pinned;
		logic                dirty;
		logic [TABLE_W-1:0]  table_id;
		logic [FILE_W-1:0]   file_id;
		logic [BLOCK_W-1:0]  block_number;
		logic [AGE_BITS-1:0] age;
	} entry_t;

	// Outcome of one pass over all frames.
	typedef struct packed {
		logic                hit;
		logic [SLOT_W-1:0]   hit_idx;
		logic                free;
		logic [SLOT_W-1:0]   free_idx;
		logic [SLOT_W-1:0]   max_idx;
		logic                victim_wb;
		logic [FILE_W-1:0]   victim_file;
		logic [BLOCK_W-1:0]  victim_block;
	} scan_res_t;

endpackage

// ===== rtl/core/bpsm_scan.sv =====
// Frame scan unit: while step is high, compares one frame per cycle with
// the request and tracks first hit, free and oldest frame. Uses bpsm_pkg.
module bpsm_scan import bpsm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [SLOT_W-1:0]  idx,
	input  entry_t             entry,
	input  logic               match_en,
	input  logic [FILE_W-1:0]  req_file,
	input  logic [BLOCK_W-1:0] req_block,
	input  logic [TABLE_W-1:0] req_table,
	output scan_res_t          res
);

	logic                first;
	logic                is_match;
	logic                is_free;
	logic                is_older;
	logic [AGE_BITS-1:0] best_age_q;
	scan_res_t           res_q;

	assign first    = (idx == '0);
	assign is_match = match_en && entry.valid && entry.file_id == req_file &&
		entry.block_number == req_block && entry.table_id == req_table;
	assign is_free  = (entry.table_id == '0) && !entry.pinned;
	assign is_older = first || (entry.age > best_age_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q      <= '0;
			best_age_q <= '0;
		end else if (step) begin
			if (is_match && (first || !res_q.hit)) begin
				res_q.hit     <= 1'b1;
				res_q.hit_idx <= idx;
			end else if (first) begin
				res_q.hit <= 1'b0;
			end
			if (is_free && (first || !res_q.free)) begin
				res_q.free     <= 1'b1;
				res_q.free_idx <= idx;
			end else if (first) begin
				res_q.free <= 1'b0;
			end
			// strictly greater keeps the first frame among equal ages
			if (is_older) begin
				best_age_q         <= entry.age;
				res_q.max_idx      <= idx;
				res_q.victim_wb    <= entry.dirty && (entry.table_id != '0);
				res_q.victim_file  <= entry.file_id;
				res_q.victim_block <= entry.block_number;
			end
		end
	end

	assign res = res_q;

endmodule

// ===== rtl/core/buffer_pool_slot_manager_core.sv =====
// Top level of the buffer pool slot manager: frame tag store, sequencer
// and result register. Uses bpsm_pkg and bpsm_scan.
//
// Read and new block run one pass of the shared scan unit over the 16
// frames, one frame per cycle, then a commit state, with done in the cycle
// after. Unpin and mark dirty give done in the cycle after start. Flush
// all gives one result per cycle, frame 0 first, last on frame 15. Codes
// 5 to 7 give no result. busy is high while an item is in progress; done
// marks each result for exactly one cycle and cannot be held off, so the
// receiver must take it.
module buffer_pool_slot_manager_core import bpsm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [OP_W-1:0]    operation,
	input  logic [FILE_W-1:0]  file_id,
	input  logic [BLOCK_W-1:0] block_number,
	input  logic [TABLE_W-1:0] table_id,
	input  logic [SLOT_W-1:0]  slot,
	output logic               done,
	output logic [SLOT_W-1:0]  frame,
	output logic               hit,
	output logic               needs_fetch,
	output logic               write_back,
	output logic [FILE_W-1:0]  victim_file,
	output logic [BLOCK_W-1:0] victim_block,
	output logic               last
);

	state_t state_q;
	logic [SLOT_W-1:0]  idx_q;
	logic [OP_W-1:0]    op_q;
	logic [FILE_W-1:0]  file_q;
	logic [BLOCK_W-1:0] block_q;
	logic [TABLE_W-1:0] table_q;

	logic                valid_q  [SLOTS];
	logic                pinned_q [SLOTS];
	logic                dirty_q  [SLOTS];
	logic [TABLE_W-1:0]  table_qa [SLOTS];
	logic [FILE_W-1:0]   file_qa  [SLOTS];
	logic [BLOCK_W-1:0]  block_qa [SLOTS];
	logic [AGE_BITS-1:0] age_q    [SLOTS];

	logic               done_q;
	logic [SLOT_W-1:0]  frame_q;
	logic               hit_q;
	logic               fetch_q;
	logic               wb_q;
	logic [FILE_W-1:0]  vfile_q;
	logic [BLOCK_W-1:0] vblock_q;
	logic               last_q;

	entry_t            rd_entry;
	scan_res_t         scan;
	logic              accept;
	logic              use_hit;
	logic              evict;
	logic              flush_wb;
	logic [SLOT_W-1:0] pick;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	always_comb begin
		rd_entry.valid        = valid_q[idx_q];
		rd_entry.pinned       = pinned_q[idx_q];
		rd_entry.dirty        = dirty_q[idx_q];
		rd_entry.table_id     = table_qa[idx_q];
		rd_entry.file_id      = file_qa[idx_q];
		rd_entry.block_number = block_qa[idx_q];
		rd_entry.age          = age_q[idx_q];
	end

	bpsm_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (state_q == ST_SCAN),
		.idx          (idx_q),
		.entry        (rd_entry),
		.match_en     (op_q == OP_READ),
		.req_file     (file_q),
		.req_block    (block_q),
		.req_table    (table_q),
		.res          (scan)
	);

	assign use_hit  = scan.hit;
	assign evict    = !scan.hit && !scan.free;
	assign flush_wb = rd_entry.dirty && (rd_entry.table_id != '0);

	always_comb begin
		priority if (scan.hit) begin
			pick = scan.hit_idx;
		end else if (scan.free) begin
			pick = scan.free_idx;
		end else begin
			pick = scan.max_idx;
		end
	end

	// sequencer and request capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			op_q    <= OP_READ;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q  <= operation;
						idx_q <= '0;
						if (operation == OP_READ || operation == OP_NEW) begin
							state_q <= ST_SCAN;
						end else if (operation == OP_FLUSH) begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST_IDX) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					state_q <= ST_IDLE;
				end
				ST_FLUSH: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			file_q  <= file_id;
			block_q <= block_number;
			table_q <= table_id;
		end
	end

	// frame store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				valid_q[i]  <= 1'b0;
				pinned_q[i] <= 1'b0;
				dirty_q[i]  <= 1'b0;
				table_qa[i] <= '0;
				file_qa[i]  <= '0;
				block_qa[i] <= '0;
				age_q[i]    <= '0;
			end
		end else begin
			if (accept && operation == OP_UNPIN) begin
				pinned_q[slot] <= 1'b0;
			end
			if (accept && operation == OP_DIRTY) begin
				dirty_q[slot] <= 1'b1;
			end
			if (state_q == ST_COMMIT) begin
				for (int i = 0; i < SLOTS; i++) begin
					if (SLOT_W'(i) != pick && !pinned_q[i] && age_q[i] != AGE_MAX) begin
						age_q[i] <= age_q[i] + 1'b1;
					end
				end
				pinned_q[pick] <= 1'b1;
				if (!use_hit) begin
					valid_q[pick]  <= 1'b1;
					file_qa[pick]  <= file_q;
					block_qa[pick] <= block_q;
					table_qa[pick] <= table_q;
					if (evict) begin
						age_q[pick] <= '0;
					end
					if (op_q == OP_NEW) begin
						dirty_q[pick] <= 1'b1;
					end else if (evict) begin
						dirty_q[pick] <= 1'b0;
					end
				end
			end
			if (state_q == ST_FLUSH) begin
				valid_q[idx_q]  <= 1'b0;
				pinned_q[idx_q] <= 1'b0;
				dirty_q[idx_q]  <= 1'b0;
				table_qa[idx_q] <= '0;
				file_qa[idx_q]  <= '0;
				block_qa[idx_q] <= '0;
				age_q[idx_q]    <= '0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (accept && (operation == OP_UNPIN || operation == OP_DIRTY)) ||
				(state_q == ST_COMMIT) || (state_q == ST_FLUSH);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_COMMIT) begin
			frame_q  <= pick;
			hit_q    <= use_hit;
			fetch_q  <= !use_hit && (op_q == OP_READ);
			wb_q     <= evict && scan.victim_wb;
			vfile_q  <= (evict && scan.victim_wb) ? scan.victim_file : '0;
			vblock_q <= (evict && scan.victim_wb) ? scan.victim_block : '0;
			last_q   <= 1'b1;
		end else if (state_q == ST_FLUSH) begin
			frame_q  <= idx_q;
			hit_q    <= 1'b0;
			fetch_q  <= 1'b0;
			wb_q     <= flush_wb;
			vfile_q  <= flush_wb ? rd_entry.file_id : '0;
			vblock_q <= flush_wb ? rd_entry.block_number : '0;
			last_q   <= (idx_q == LAST_IDX);
		end else if (accept) begin
			frame_q  <= slot;
			hit_q    <= 1'b0;
			fetch_q  <= 1'b0;
			wb_q     <= 1'b0;
			vfile_q  <= '0;
			vblock_q <= '0;
			last_q   <= 1'b1;
		end
	end

	assign done         = done_q;
	assign frame        = frame_q;
	assign hit          = hit_q;
	assign needs_fetch  = fetch_q;
	assign write_back   = wb_q;
	assign victim_file  = vfile_q;
	assign victim_block = vblock_q;
	assign last         = last_q;

endmodule

// ===== verif/buffer_pool_slot_manager_scoreboard.sv =====
`timescale 1ns / 100ps
// Scoreboard for buffer_pool_slot_manager_core: tracks frame tags, predicts results, compares.
// Depends on bpsm_pkg; instantiated beside the core by buffer_pool_slot_manager_core_tb.
module buffer_pool_slot_manager_scoreboard import bpsm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [OP_W-1:0]    operation,
	input  logic [FILE_W-1:0]  file_id,
	input  logic [BLOCK_W-1:0] block_number,
	input  logic [TABLE_W-1:0] table_id,
	input  logic [SLOT_W-1:0]  slot,
	input  logic               done,
	input  logic [SLOT_W-1:0]  frame,
	input  logic               hit,
	input  logic               needs_fetch,
	input  logic               write_back,
	input  logic [FILE_W-1:0]  victim_file,
	input  logic [BLOCK_W-1:0] victim_block,
	input  logic               last,
	output int                 errors,
	output int                 pending,
	output int                 requests,
	output int                 results,
	output int                 hits,
	output int                 write_backs
);

	typedef struct packed {
		logic [SLOT_W-1:0]  frame;
		logic               hit;
		logic               fetch;
		logic               wb;
		logic [FILE_W-1:0]  vfile;
		logic [BLOCK_W-1:0] vblock;
		logic               last;
	} outcome_t;

	outcome_t due_results[$];

	logic                f_valid  [SLOTS];
	logic                f_pinned [SLOTS];
	logic                f_dirty  [SLOTS];
	logic [TABLE_W-1:0]  f_table  [SLOTS];
	logic [FILE_W-1:0]   f_file   [SLOTS];
	logic [BLOCK_W-1:0]  f_block  [SLOTS];
	logic [AGE_BITS-1:0] f_age    [SLOTS];

	int err_count = 0;
	int req_count = 0;
	int res_count = 0;
	int hit_count = 0;
	int wb_count  = 0;

	assign errors      = err_count;
	assign pending     = due_results.size();
	assign requests    = req_count;
	assign results     = res_count;
	assign hits        = hit_count;
	assign write_backs = wb_count;

	task automatic clear_entry(input int i);
		f_valid[i]  = 1'b0;
		f_pinned[i] = 1'b0;
		f_dirty[i]  = 1'b0;
		f_table[i]  = '0;
		f_file[i]   = '0;
		f_block[i]  = '0;
		f_age[i]    = '0;
	endtask

	// pin the used frame, age every other unpinned one (saturating)
	task automatic touch(input int n);
		for (int i = 0; i < SLOTS; i++) begin
			if (i == n)
				f_pinned[i] = 1'b1;
			else if (!f_pinned[i] && f_age[i] != AGE_MAX)
				f_age[i] = f_age[i] + 1'b1;
		end
	endtask

	// free frame first; otherwise the first frame of largest age, pinned or not
	task automatic claim_frame(output int n, output logic wb,
			output logic [FILE_W-1:0] vf, output logic [BLOCK_W-1:0] vb);
		logic [AGE_BITS-1:0] oldest;
		wb = 1'b0;
		vf = '0;
		vb = '0;
		n  = -1;
		for (int i = 0; i < SLOTS; i++)
			if (n < 0 && f_table[i] == '0 && !f_pinned[i])
				n = i;
		if (n >= 0)
			return;
		n = 0;
		oldest = f_age[0];
		for (int i = 1; i < SLOTS; i++)
			if (f_age[i] > oldest) begin
				oldest = f_age[i];
				n = i;
			end
		if (f_dirty[n] && f_table[n] != '0) begin
			wb = 1'b1;
			vf = f_file[n];
			vb = f_block[n];
		end
		clear_entry(n);
	endtask

	task automatic apply_request(input logic [OP_W-1:0] op, input logic [FILE_W-1:0] f,
			input logic [BLOCK_W-1:0] b, input logic [TABLE_W-1:0] t,
			input logic [SLOT_W-1:0] s);
		int n;
		logic wb;
		logic [FILE_W-1:0] vf;
		logic [BLOCK_W-1:0] vb;
		outcome_t o;
		o = '0;
		o.last = 1'b1;
		case (op)
			OP_READ, OP_NEW: begin
				if (op == OP_READ)
					for (int i = 0; i < SLOTS; i++)
						if (f_valid[i] && f_file[i] == f && f_block[i] == b && f_table[i] == t) begin
							touch(i);
							o.frame = SLOT_W'(i);
							o.hit = 1'b1;
							due_results.push_back(o);
							return;
						end
				claim_frame(n, wb, vf, vb);
				f_valid[n] = 1'b1;
				f_file[n]  = f;
				f_block[n] = b;
				f_table[n] = t;
				touch(n);
				if (op == OP_NEW)
					f_dirty[n] = 1'b1;
				o.frame  = SLOT_W'(n);
				o.fetch  = (op == OP_READ);
				o.wb     = wb;
				o.vfile  = vf;
				o.vblock = vb;
				due_results.push_back(o);
			end
			OP_UNPIN, OP_DIRTY: begin
				if (s < SLOTS) begin
					if (op == OP_UNPIN)
						f_pinned[s] = 1'b0;
					else
						f_dirty[s] = 1'b1;
				end
				o.frame = s;
				due_results.push_back(o);
			end
			OP_FLUSH: begin
				for (int i = 0; i < SLOTS; i++) begin
					o = '0;
					o.frame = SLOT_W'(i);
					o.wb = f_dirty[i] && f_table[i] != '0;
					if (o.wb) begin
						o.vfile  = f_file[i];
						o.vblock = f_block[i];
					end
					o.last = (i == SLOTS - 1);
					due_results.push_back(o);
					clear_entry(i);
				end
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: %s got 0x%0h, want 0x%0h", $time, field, got, want);
		err_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				clear_entry(i);
			due_results.delete();
		end else begin
			// compare before predicting: a result never belongs to the item taken at the same edge
			if (done === 1'b1) begin
				res_count++;
				if (hit === 1'b1)
					hit_count++;
				if (write_back === 1'b1)
					wb_count++;
				if (due_results.size() == 0)
					report_mismatch("result with nothing due, frame", 32'(frame), 32'd0);
				else begin
					want = due_results.pop_front();
					if (frame !== want.frame)
						report_mismatch("frame", 32'(frame), 32'(want.frame));
					if (hit !== want.hit)
						report_mismatch("hit", 32'(hit), 32'(want.hit));
					if (needs_fetch !== want.fetch)
						report_mismatch("needs_fetch", 32'(needs_fetch), 32'(want.fetch));
					if (write_back !== want.wb)
						report_mismatch("write_back", 32'(write_back), 32'(want.wb));
					if (victim_file !== want.vfile)
						report_mismatch("victim_file", 32'(victim_file), 32'(want.vfile));
					if (victim_block !== want.vblock)
						report_mismatch("victim_block", 32'(victim_block),
							32'(want.vblock));
					if (last !== want.last)
						report_mismatch("last", 32'(last), 32'(want.last));
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				req_count++;
				apply_request(operation, file_id, block_number, table_id, slot);
			end
		end
	end

endmodule

// ===== verif/buffer_pool_slot_manager_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for buffer_pool_slot_manager_core: clock, reset, request stimulus, verdict.
// Depends on bpsm_pkg, the core and buffer_pool_slot_manager_scoreboard.
module buffer_pool_slot_manager_core_tb;
	import bpsm_pkg::*;

	localparam int RANDOM_ITEMS  = 345;
	localparam int STALL_LIMIT   = 1000;
	localparam int SETTLE_CYCLES = 24;
	localparam int POOL          = 8;
	localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [OP_W-1:0]    operation;
	logic [FILE_W-1:0]  file_id;
	logic [BLOCK_W-1:0] block_number;
	logic [TABLE_W-1:0] table_id;
	logic [SLOT_W-1:0]  slot;
	logic               done;
	logic [SLOT_W-1:0]  frame;
	logic               hit;
	logic               needs_fetch;
	logic               write_back;
	logic [FILE_W-1:0]  victim_file;
	logic [BLOCK_W-1:0] victim_block;
	logic               last;

	int errors, pending, requests, results, hits, write_backs;
	int stall_cycles = 0;
	int issued = 0;
	int ignored = 0;

	// recently used addresses, replayed to provoke hits
	logic [FILE_W-1:0]  pool_file  [POOL];
	logic [BLOCK_W-1:0] pool_block [POOL];
	logic [TABLE_W-1:0] pool_table [POOL];
	int pool_wr = 0;
	int pool_fill = 0;

	always #1 clk = ~clk;

	buffer_pool_slot_manager_core dut (.*);

	buffer_pool_slot_manager_scoreboard sb (.*);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else if (stall_cycles == STALL_LIMIT) begin
				$display("stalled for %0d cycles", STALL_LIMIT);
				$display("Mismatches found");
				$finish;
			end else
				stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send(input logic [OP_W-1:0] op, input logic [FILE_W-1:0] f,
			input logic [BLOCK_W-1:0] b, input logic [TABLE_W-1:0] t,
			input logic [SLOT_W-1:0] s);
		@(negedge clk);
		operation    <= op;
		file_id      <= f;
		block_number <= b;
		table_id     <= t;
		slot         <= s;
		start        <= 1'b1;
		do @(posedge clk); while (busy);
		if (op > OP_FLUSH)
			ignored++;
		else
			issued++;
		if (op == OP_READ || op == OP_NEW) begin
			pool_file[pool_wr]  = f;
			pool_block[pool_wr] = b;
			pool_table[pool_wr] = t;
			pool_wr = (pool_wr + 1) % POOL;
			if (pool_fill < POOL)
				pool_fill++;
		end
	endtask

	task automatic pause(input int n);
		@(negedge clk);
		start <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic make_request(output logic [OP_W-1:0] op, output logic [FILE_W-1:0] f,
			output logic [BLOCK_W-1:0] b, output logic [TABLE_W-1:0] t,
			output logic [SLOT_W-1:0] s);
		int r, pick, tsel;
		r    = $urandom_range(99);
		tsel = $urandom_range(9);
		f = FILE_W'($urandom_range(255));
		b = BLOCK_W'($urandom);
		if ($urandom_range(3) != 0)
			b = BLOCK_W'($urandom_range(63));
		t = TABLE_W'($urandom);
		if (tsel == 0)
			t = '0;
		else if (tsel < 7)
			t = TABLE_W'($urandom_range(7, 1));
		s = SLOT_W'($urandom_range(15));
		if (r < 45) begin
			op = OP_READ;
			if (pool_fill > 0 && $urandom_range(1)) begin
				pick = $urandom_range(pool_fill - 1);
				f = pool_file[pick];
				b = pool_block[pick];
				t = pool_table[pick];
			end
		end else if (r < 60)
			op = OP_NEW;
		else if (r < 85)
			op = OP_UNPIN;
		else if (r < 93)
			op = OP_DIRTY;
		else if (r < 95)
			op = OP_FLUSH;
		else
			op = OP_W'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
	endtask

	initial begin
		logic [OP_W-1:0]    op;
		logic [FILE_W-1:0]  f;
		logic [BLOCK_W-1:0] b;
		logic [TABLE_W-1:0] t;
		logic [SLOT_W-1:0]  s;
		int target;
		int burst;

		arst_n       = 1'b0;
		start        = 1'b0;
		operation    = OP_READ;
		file_id      = '0;
		block_number = '0;
		table_id     = '0;
		slot         = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// miss into a free frame, then a hit on it
		send(OP_READ, 8'h00, 24'h000000, 15'h0000, 4'h0);
		send(OP_READ, 8'h00, 24'h000000, 15'h0000, 4'h0);
		send(OP_NEW, 8'hFF, 24'hFFFFFF, 15'h7FFF, 4'hF);
		// fill the pool so no frame is free, then force eviction of a pinned, dirty frame
		for (int k = 2; k < SLOTS; k++)
			send(OP_NEW, 8'(k), 24'(k * 3), 15'(k), 4'h0);
		send(OP_READ, 8'h01, 24'h000001, 15'h0001, 4'h0);
		send(OP_UNPIN, 8'h00, 24'h000000, 15'h0000, 4'h0);
		send(OP_DIRTY, 8'hFF, 24'hFFFFFF, 15'h7FFF, 4'hF);
		send(OP_UNPIN, 8'hAA, 24'h555555, 15'h2AAA, 4'hF);
		send(OP_RSVD_LO, 8'hFF, 24'hFFFFFF, 15'h7FFF, 4'hF);
		send(OP_RSVD_HI, 8'h00, 24'h000000, 15'h0000, 4'h0);
		send(OP_READ, 8'hFF, 24'hFFFFFF, 15'h7FFF, 4'hA);
		send(OP_FLUSH, 8'h55, 24'hAAAAAA, 15'h5555, 4'h5);
		send(OP_READ, 8'h80, 24'h800000, 15'h4000, 4'h8);

		target = issued + RANDOM_ITEMS;
		while (issued < target) begin
			burst = $urandom_range(12, 1);
			repeat (burst) begin
				make_request(op, f, b, t, s);
				send(op, f, b, t, s);
			end
			if ($urandom_range(3) != 0)
				pause($urandom_range(25, 1));
		end
		pause(1);

		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d requests (%0d with unused codes), %0d results checked,",
			requests, ignored, results);
		$display("including %0d read hits and %0d write-backs.", hits, write_backs);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/bpsm_pkg.sv
rtl/core/bpsm_scan.sv
rtl/core/buffer_pool_slot_manager_core.sv
verif/buffer_pool_slot_manager_scoreboard.sv
verif/buffer_pool_slot_manager_core_tb.sv
